FILE: hw/rtl/gelut_pkg.sv
package gelut_pkg;

    localparam int TABLE_LEN   = 512;
    localparam int IDX_W       = $clog2(TABLE_LEN);
    localparam int RAM_DEPTH   = 3 * TABLE_LEN;
    localparam int ADDR_W      = $clog2(RAM_DEPTH);
    localparam int QUEUE_DEPTH = 4;

    localparam int VOICE_W    = 4;
    localparam int POS_W      = 16;
    localparam int LEVEL_W    = 16;
    localparam int GSIZE_W    = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [1:0] {
        SHAPE_BELL   = 2'd0,
        SHAPE_PERC   = 2'd1,
        SHAPE_SWELL  = 2'd2,
        SHAPE_SILENT = 2'd3
    } shape_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRAIN_SIZE   = 1'b0,
        CFG_SHAPE_SELECT = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic [VOICE_W-1:0] voice_id;
        logic [POS_W-1:0]   grain_position;
    } in_item_t;

    typedef struct packed {
        logic [VOICE_W-1:0] voice_out;
        logic [LEVEL_W-1:0] level;
    } out_item_t;

    typedef struct packed {
        logic [GSIZE_W-1:0] grain_size;
        shape_t             shape;
    } cfg_t;

    // one classified beat between front and back
    typedef struct packed {
        logic [VOICE_W-1:0] voice;
        logic               zero;
        logic [GSIZE_W-1:0] rem;
        logic [ADDR_W-1:0]  addr0;
        logic [ADDR_W-1:0]  addr1;
    } q_entry_t;

endpackage

FILE: hw/rtl/gelut_ram.sv
module gelut_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (rd_en)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

FILE: hw/rtl/gelut_front.sv
module gelut_front
    import gelut_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  cfg_t     cfg,
    input  logic     enable,
    input  logic     in_valid,
    output logic     in_ready,
    input  in_item_t in_data,
    input  logic     q_full,
    output logic     push,
    output q_entry_t push_data
);

    localparam int P_W = POS_W + IDX_W;
    localparam int NST = IDX_W + 1;

    logic [NST-1:0]     valid_reg;
    logic [VOICE_W-1:0] voice_reg [NST];
    logic               zero_reg  [NST];
    logic [GSIZE_W-1:0] rem_reg   [NST];
    logic [IDX_W-1:0]   low_reg   [NST];
    logic [IDX_W-1:0]   quo_reg   [NST];

    logic               adv;
    logic               accept;
    logic [P_W-1:0]     p_full;
    logic [IDX_W-1:0]   i0;
    logic [IDX_W-1:0]   i1;
    logic [ADDR_W-1:0]  base;

    assign adv      = !(valid_reg[IDX_W] && q_full);
    assign in_ready = adv && enable;
    assign accept   = in_valid && in_ready;
    assign p_full   = P_W'(in_data.grain_position) * P_W'(TABLE_LEN);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= {valid_reg[NST-2:0], accept};
        end
    end

    // p >> IDX_W is below grain_size for in-range positions, so the quotient fits IDX_W bits
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            voice_reg[0] <= in_data.voice_id;
            zero_reg[0]  <= (cfg.shape == SHAPE_SILENT) ||
                            (in_data.grain_position >= cfg.grain_size);
            rem_reg[0]   <= p_full[P_W-1:IDX_W];
            low_reg[0]   <= p_full[IDX_W-1:0];
            quo_reg[0]   <= '0;
        end
    end

    // restoring divide, one quotient bit per stage
    for (genvar s = 0; s < IDX_W; s++)
    begin : g_div
        logic [GSIZE_W:0] trial;
        logic [GSIZE_W:0] diff;
        logic             take;

        assign trial = {rem_reg[s], low_reg[s][IDX_W-1]};
        assign diff  = trial - {1'b0, cfg.grain_size};
        assign take  = trial >= {1'b0, cfg.grain_size};

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                voice_reg[s+1] <= voice_reg[s];
                zero_reg[s+1]  <= zero_reg[s];
                rem_reg[s+1]   <= take ? diff[GSIZE_W-1:0] : trial[GSIZE_W-1:0];
                low_reg[s+1]   <= low_reg[s] << 1;
                quo_reg[s+1]   <= {quo_reg[s][IDX_W-2:0], take};
            end
        end
    end

    always_comb
    begin
        if (quo_reg[IDX_W] > IDX_W'(TABLE_LEN - 1))
        begin
            i0 = IDX_W'(TABLE_LEN - 1);
        end
        else
        begin
            i0 = quo_reg[IDX_W];
        end
        // upper neighbor of the last entry wraps to entry 0
        if (i0 == IDX_W'(TABLE_LEN - 1))
        begin
            i1 = '0;
        end
        else
        begin
            i1 = i0 + 1'b1;
        end
        case (cfg.shape)
            SHAPE_PERC:  base = ADDR_W'(TABLE_LEN);
            SHAPE_SWELL: base = ADDR_W'(2 * TABLE_LEN);
            default:     base = '0;
        endcase
        push_data.voice = voice_reg[IDX_W];
        push_data.zero  = zero_reg[IDX_W];
        push_data.rem   = rem_reg[IDX_W];
        push_data.addr0 = base + ADDR_W'(i0);
        push_data.addr1 = base + ADDR_W'(i1);
    end

    assign push = valid_reg[IDX_W] && adv;

endmodule

FILE: hw/rtl/gelut_queue.sv
module gelut_queue
    import gelut_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  q_entry_t push_data,
    output logic     full,
    input  logic     pop,
    output q_entry_t pop_data,
    output logic     empty
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    q_entry_t         mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full     = count_reg == CNT_W'(QUEUE_DEPTH);
    assign empty    = count_reg == '0;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

FILE: hw/rtl/gelut_back.sv
module gelut_back
    import gelut_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    output logic      fill_done,
    input  logic      q_empty,
    input  q_entry_t  pop_data,
    output logic      pop,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    localparam int HALF_LEN = (TABLE_LEN + 1) / 2;
    localparam int HALF_W   = $clog2(HALF_LEN);
    localparam int NUM_W    = GSIZE_W + LEVEL_W;

    localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] LEN64       = 64'(TABLE_LEN);
    localparam logic [63:0] LEN7        = 64'(7 * TABLE_LEN);
    localparam logic [63:0] UNITY64     = 64'd32768;

    typedef logic [LEVEL_W-1:0] half_tab_t [HALF_LEN];

    // (1 - cos(pi*t))/2 via sin^2, Q30 Taylor series, evaluated at elaboration
    function automatic logic [LEVEL_W-1:0] raised_cos(input logic [63:0] num,
                                                      input logic        long_den);
        logic [63:0] n;
        logic [63:0] t;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] h;
        logic [63:0] p;
        logic [63:0] s;
        logic [63:0] v;
        n = num;
        if (long_den)
        begin
            if (n > LEN7)
                n = LEN7;
            t = ((n << 30) + LEN7 / 2) / LEN7;
        end
        else
        begin
            if (n > LEN64)
                n = LEN64;
            t = ((n << 30) + LEN64 / 2) / LEN64;
        end
        x  = (t * HALF_PI_Q30 + (Q30_ONE >> 1)) >> 30;
        x2 = (x * x + (Q30_ONE >> 1)) >> 30;
        h  = Q30_ONE;
        p  = ((x2 * h) >> 30) / 64'd156;
        h  = (p >= Q30_ONE) ? 64'd0 : Q30_ONE - p;
        p  = ((x2 * h) >> 30) / 64'd110;
        h  = (p >= Q30_ONE) ? 64'd0 : Q30_ONE - p;
        p  = ((x2 * h) >> 30) / 64'd72;
        h  = (p >= Q30_ONE) ? 64'd0 : Q30_ONE - p;
        p  = ((x2 * h) >> 30) / 64'd42;
        h  = (p >= Q30_ONE) ? 64'd0 : Q30_ONE - p;
        p  = ((x2 * h) >> 30) / 64'd20;
        h  = (p >= Q30_ONE) ? 64'd0 : Q30_ONE - p;
        p  = ((x2 * h) >> 30) / 64'd6;
        h  = (p >= Q30_ONE) ? 64'd0 : Q30_ONE - p;
        s  = (x * h) >> 30;
        if (s > Q30_ONE)
            s = Q30_ONE;
        v = (s * s + (64'd1 << 44)) >> 45;
        if (v > UNITY64)
            v = UNITY64;
        return v[LEVEL_W-1:0];
    endfunction

    function automatic logic [LEVEL_W-1:0] envelope_entry(input shape_t      shape,
                                                          input logic [63:0] n);
        logic [LEVEL_W-1:0] e;
        case (shape)
            SHAPE_BELL:
                e = (64'd2 * n <= LEN64) ? raised_cos(64'd2 * n, 1'b0)
                                         : raised_cos(64'd2 * (LEN64 - n), 1'b0);
            SHAPE_PERC:
                e = (64'd8 * n <= LEN64) ? raised_cos(64'd8 * n, 1'b0)
                                         : raised_cos(64'd8 * (LEN64 - n), 1'b1);
            SHAPE_SWELL:
                e = (64'd8 * n <= LEN7) ? raised_cos(64'd8 * n, 1'b1)
                                        : raised_cos(64'd8 * (LEN64 - n), 1'b0);
            default:
                e = '0;
        endcase
        return e;
    endfunction

    function automatic half_tab_t build_half(input shape_t shape, input logic upper);
        half_tab_t   tab;
        logic [63:0] n;
        for (int i = 0; i < HALF_LEN; i++)
        begin
            n      = upper ? 64'(i + HALF_LEN) : 64'(i);
            tab[i] = (n < LEN64) ? envelope_entry(shape, n) : '0;
        end
        return tab;
    endfunction

    localparam half_tab_t BELL_LO  = build_half(SHAPE_BELL, 1'b0);
    localparam half_tab_t BELL_HI  = build_half(SHAPE_BELL, 1'b1);
    localparam half_tab_t PERC_LO  = build_half(SHAPE_PERC, 1'b0);
    localparam half_tab_t PERC_HI  = build_half(SHAPE_PERC, 1'b1);
    localparam half_tab_t SWELL_LO = build_half(SHAPE_SWELL, 1'b0);
    localparam half_tab_t SWELL_HI = build_half(SHAPE_SWELL, 1'b1);

    // ---------------- envelope memory load after reset ----------------
    logic               fill_run_reg;
    shape_t             fill_shape_reg;
    logic [IDX_W-1:0]   fill_idx_reg;
    logic [ADDR_W-1:0]  fill_ptr_reg;
    logic               fill_wr_reg;
    logic [ADDR_W-1:0]  fill_addr_reg;
    logic [LEVEL_W-1:0] fill_data_reg;
    logic [LEVEL_W-1:0] fill_src;
    logic [IDX_W-1:0]   hi_idx;
    logic               upper;

    assign hi_idx    = fill_idx_reg - IDX_W'(HALF_LEN);
    assign upper     = fill_idx_reg >= IDX_W'(HALF_LEN);
    assign fill_done = !fill_run_reg && !fill_wr_reg;

    always_comb
    begin
        case (fill_shape_reg)
            SHAPE_BELL:
                fill_src = upper ? BELL_HI[hi_idx[HALF_W-1:0]]
                                 : BELL_LO[fill_idx_reg[HALF_W-1:0]];
            SHAPE_PERC:
                fill_src = upper ? PERC_HI[hi_idx[HALF_W-1:0]]
                                 : PERC_LO[fill_idx_reg[HALF_W-1:0]];
            SHAPE_SWELL:
                fill_src = upper ? SWELL_HI[hi_idx[HALF_W-1:0]]
                                 : SWELL_LO[fill_idx_reg[HALF_W-1:0]];
            default:
                fill_src = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_run_reg   <= 1'b1;
            fill_shape_reg <= SHAPE_BELL;
            fill_idx_reg   <= '0;
            fill_ptr_reg   <= '0;
            fill_wr_reg    <= 1'b0;
        end
        else
        begin
            fill_wr_reg <= fill_run_reg;
            if (fill_run_reg)
            begin
                fill_ptr_reg <= fill_ptr_reg + 1'b1;
                if (fill_idx_reg == IDX_W'(TABLE_LEN - 1))
                begin
                    fill_idx_reg <= '0;
                    case (fill_shape_reg)
                        SHAPE_BELL:  fill_shape_reg <= SHAPE_PERC;
                        SHAPE_PERC:  fill_shape_reg <= SHAPE_SWELL;
                        default:     fill_run_reg   <= 1'b0;
                    endcase
                end
                else
                begin
                    fill_idx_reg <= fill_idx_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        fill_addr_reg <= fill_ptr_reg;
        fill_data_reg <= fill_src;
    end

    // ---------------- interpolation pipeline ----------------
    logic                adv;
    logic                take_item;
    logic [LEVEL_W-1:0]  t0;
    logic [LEVEL_W-1:0]  t1;

    logic                b1_valid_reg;
    logic [VOICE_W-1:0]  b1_voice_reg;
    logic                b1_zero_reg;
    logic [GSIZE_W-1:0]  b1_rem_reg;

    logic                b2_valid_reg;
    logic [VOICE_W-1:0]  b2_voice_reg;
    logic                b2_zero_reg;
    logic [NUM_W-1:0]    prod0_reg;
    logic [NUM_W-1:0]    prod1_reg;

    logic [LEVEL_W:0]    d_valid_reg;
    logic [VOICE_W-1:0]  d_voice_reg [LEVEL_W+1];
    logic                d_zero_reg  [LEVEL_W+1];
    logic [GSIZE_W-1:0]  d_rem_reg   [LEVEL_W+1];
    logic [LEVEL_W-1:0]  d_low_reg   [LEVEL_W+1];
    logic [LEVEL_W-1:0]  d_quo_reg   [LEVEL_W+1];

    logic                out_valid_reg;
    out_item_t           out_data_reg;
    logic [NUM_W-1:0]    num;

    assign adv       = !out_valid_reg || out_ready;
    assign take_item = !q_empty && fill_done;
    assign pop       = take_item && adv;

    gelut_ram #(
        .WIDTH (LEVEL_W),
        .DEPTH (RAM_DEPTH)
    ) u_env_ram (
        .clk     (clk),
        .we      (fill_wr_reg),
        .waddr   (fill_addr_reg),
        .wdata   (fill_data_reg),
        .rd_en   (adv),
        .raddr_a (pop_data.addr0),
        .raddr_b (pop_data.addr1),
        .rdata_a (t0),
        .rdata_b (t1)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg  <= 1'b0;
            b2_valid_reg  <= 1'b0;
            d_valid_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            b1_valid_reg  <= take_item;
            b2_valid_reg  <= b1_valid_reg;
            d_valid_reg   <= {d_valid_reg[LEVEL_W-1:0], b2_valid_reg};
            out_valid_reg <= d_valid_reg[LEVEL_W];
        end
    end

    // (size - r)*T[i0] + r*T[i1] + size/2, then divided by size
    assign num = prod0_reg + prod1_reg + NUM_W'(cfg.grain_size >> 1);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b1_voice_reg <= pop_data.voice;
            b1_zero_reg  <= pop_data.zero;
            b1_rem_reg   <= pop_data.rem;

            b2_voice_reg <= b1_voice_reg;
            b2_zero_reg  <= b1_zero_reg;
            prod0_reg    <= NUM_W'(cfg.grain_size - b1_rem_reg) * NUM_W'(t0);
            prod1_reg    <= NUM_W'(b1_rem_reg) * NUM_W'(t1);

            d_voice_reg[0] <= b2_voice_reg;
            d_zero_reg[0]  <= b2_zero_reg;
            d_rem_reg[0]   <= num[NUM_W-1:LEVEL_W];
            d_low_reg[0]   <= num[LEVEL_W-1:0];
            d_quo_reg[0]   <= '0;

            out_data_reg.voice_out <= d_voice_reg[LEVEL_W];
            out_data_reg.level     <= d_zero_reg[LEVEL_W] ? '0 : d_quo_reg[LEVEL_W];
        end
    end

    for (genvar s = 0; s < LEVEL_W; s++)
    begin : g_div
        logic [GSIZE_W:0] trial;
        logic [GSIZE_W:0] diff;
        logic             take;

        assign trial = {d_rem_reg[s], d_low_reg[s][LEVEL_W-1]};
        assign diff  = trial - {1'b0, cfg.grain_size};
        assign take  = trial >= {1'b0, cfg.grain_size};

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                d_voice_reg[s+1] <= d_voice_reg[s];
                d_zero_reg[s+1]  <= d_zero_reg[s];
                d_rem_reg[s+1]   <= take ? diff[GSIZE_W-1:0] : trial[GSIZE_W-1:0];
                d_low_reg[s+1]   <= d_low_reg[s] << 1;
                d_quo_reg[s+1]   <= {d_quo_reg[s][LEVEL_W-2:0], take};
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

FILE: hw/rtl/grain_envelope_lut_interp_unit.sv
// Grain envelope lookup: one beat in, one beat out, one beat per clock sustained while out_ready
// stays high. Each beat carries a voice number and a sample position; the level is the selected
// raised-cosine table (bell, percussive, swell, or silence) interpolated linearly at position *
// TABLE_LEN / grain_size, rounded half up, in unsigned Q1.15. Positions at or past grain_size, a
// zero grain_size and the silent shape give level 0. The path is a front pipeline of
// TABLE_LEN-index divide stages (one quotient bit per stage), a 4-deep queue, then the dual-port
// envelope memory read, the interpolation multipliers and a 16-stage divide by grain_size, one
// result bit per stage. After reset the envelope memory is loaded from the built-in tables;
// in_ready stays low until that is done.
// Register writes are only allowed while no beats are in flight.
module grain_envelope_lut_interp_unit
    import gelut_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_item_t              in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_item_t             out_data
);

    localparam logic [GSIZE_W-1:0] GRAIN_SIZE_RESET = 16'd1024;

    logic [GSIZE_W-1:0] grain_size_reg;
    shape_t             shape_select_reg;
    cfg_t               cfg;
    logic               fill_done;
    logic               q_full;
    logic               q_empty;
    logic               push;
    logic               pop;
    q_entry_t           push_data;
    q_entry_t           pop_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grain_size_reg   <= GRAIN_SIZE_RESET;
            shape_select_reg <= SHAPE_BELL;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_GRAIN_SIZE:   grain_size_reg   <= cfg_data[GSIZE_W-1:0];
                CFG_SHAPE_SELECT: shape_select_reg <= shape_t'(cfg_data[1:0]);
                default:          ;
            endcase
        end
    end

    assign cfg.grain_size = grain_size_reg;
    assign cfg.shape      = shape_select_reg;

    gelut_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .enable    (fill_done),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .q_full    (q_full),
        .push      (push),
        .push_data (push_data)
    );

    gelut_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (q_empty)
    );

    gelut_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .fill_done (fill_done),
        .q_empty   (q_empty),
        .pop_data  (pop_data),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
    import gelut_pkg::*;

    localparam longint unsigned Q30_ONE     = 64'd1 << 30;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned UNITY       = 64'd32768;
    localparam int SETTLE_CYCLES = 40;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_BEATS = 1850;

    typedef struct {
        logic [GSIZE_W-1:0] size;
        shape_t             shape;
        logic [VOICE_W-1:0] voice;
        logic [POS_W-1:0]   pos;
        bit                 typed;
        logic [LEVEL_W-1:0] level;
    } vector_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    in_item_t              in_data = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    out_item_t             out_data;

    logic [LEVEL_W-1:0] bell_tab [TABLE_LEN];
    logic [LEVEL_W-1:0] perc_tab [TABLE_LEN];
    logic [LEVEL_W-1:0] swell_tab [TABLE_LEN];
    int unsigned taylor_k [6] = '{156, 110, 72, 42, 20, 6};

    logic [GSIZE_W-1:0] cur_size = 16'd1024;
    shape_t             cur_shape = SHAPE_BELL;
    out_item_t          next_level = '0;
    out_item_t          pending_levels [$];

    bit calm = 1'b0;
    int errors = 0;
    int beats_sent = 0;
    int results_checked = 0;
    int settings_applied = 0;
    int shape_beats [4] = '{0, 0, 0, 0};

    grain_envelope_lut_interp_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // (1 - cos(pi*num/den)) / 2 in Q1.15, fixed-point Taylor sine squared
    function automatic logic [LEVEL_W-1:0] raised_cos(longint unsigned num,
                                                      longint unsigned den);
        longint unsigned t, x, x2, h, s, v, p;
        if (den == 0)
            return '0;
        if (num > den)
            num = den;
        t = ((num << 30) + den / 2) / den;
        x = (t * HALF_PI_Q30 + (Q30_ONE >> 1)) >> 30;
        x2 = (x * x + (Q30_ONE >> 1)) >> 30;
        h = Q30_ONE;
        for (int k = 0; k < 6; k++)
        begin
            p = ((x2 * h) >> 30) / taylor_k[k];
            h = (p >= Q30_ONE) ? 64'd0 : Q30_ONE - p;
        end
        s = (x * h) >> 30;
        if (s > Q30_ONE)
            s = Q30_ONE;
        v = (s * s + (64'd1 << 44)) >> 45;
        if (v > UNITY)
            v = UNITY;
        return v[LEVEL_W-1:0];
    endfunction

    function automatic logic [LEVEL_W-1:0] envelope_level(logic [POS_W-1:0] pos);
        longint unsigned size, p, i0, i1, r, t0, t1, lvl;
        size = 64'(cur_size);
        if (cur_shape == SHAPE_SILENT || pos >= size)
            return '0;
        p = 64'(pos) * 64'(TABLE_LEN);
        i0 = p / size;
        r = p % size;
        i1 = i0 + 1;
        if (i0 >= 64'(TABLE_LEN))
            i0 = 64'(TABLE_LEN - 1);
        if (i1 >= 64'(TABLE_LEN))
            i1 = 0;
        case (cur_shape)
            SHAPE_BELL:
            begin
                t0 = 64'(bell_tab[i0]);
                t1 = 64'(bell_tab[i1]);
            end
            SHAPE_PERC:
            begin
                t0 = 64'(perc_tab[i0]);
                t1 = 64'(perc_tab[i1]);
            end
            default:
            begin
                t0 = 64'(swell_tab[i0]);
                t1 = 64'(swell_tab[i1]);
            end
        endcase
        lvl = ((size - r) * t0 + r * t1 + size / 2) / size;
        if (lvl > UNITY)
            lvl = UNITY;
        return lvl[LEVEL_W-1:0];
    endfunction

    // mostly back-to-back, sometimes short, rarely long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    task automatic send_beat(logic [VOICE_W-1:0] voice, logic [POS_W-1:0] pos,
                             bit typed, logic [LEVEL_W-1:0] typed_level);
        int gap;
        out_item_t exp_item;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        exp_item.voice_out = voice;
        exp_item.level = typed ? typed_level : envelope_level(pos);
        next_level <= exp_item;
        in_valid <= 1'b1;
        in_data <= '{voice_id: voice, grain_position: pos};
        do
            @(posedge clk);
        while (!in_ready);
        beats_sent++;
        shape_beats[cur_shape]++;
    endtask

    // only while idle: drain everything, let the pipe settle, then write both registers
    task automatic apply_setting(logic [GSIZE_W-1:0] size, shape_t shape);
        in_valid <= 1'b0;
        // wait until the monitor has queued the last accepted beat
        @(posedge clk);
        while (pending_levels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= CFG_GRAIN_SIZE;
        cfg_data <= size;
        @(posedge clk);
        cfg_index <= CFG_SHAPE_SELECT;
        cfg_data <= {14'($urandom), shape};
        @(posedge clk);
        cfg_we <= 1'b0;
        cur_size = size;
        cur_shape = shape;
        settings_applied++;
    endtask

    always @(posedge clk)
    begin : ready_gen
        int stall_left;
        if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
            if (!calm && $urandom_range(0, 3) == 0)
                stall_left = pick_gap();
        end
    end

    always @(posedge clk)
    begin : monitor
        int idle_cycles;
        out_item_t exp_item;
        if (in_valid && in_ready)
            pending_levels.push_back(next_level);
        if (out_valid && out_ready)
        begin
            if (pending_levels.size() == 0)
            begin
                $display("%0t: unexpected beat voice %0d level %0d", $time,
                         out_data.voice_out, out_data.level);
                errors++;
            end
            else
            begin
                exp_item = pending_levels.pop_front();
                results_checked++;
                if (out_data.voice_out !== exp_item.voice_out)
                begin
                    $display("%0t: voice_out expected %0d got %0d", $time,
                             exp_item.voice_out, out_data.voice_out);
                    errors++;
                end
                if (out_data.level !== exp_item.level)
                begin
                    $display("%0t: level expected %0d got %0d (voice %0d)", $time,
                             exp_item.level, out_data.level, exp_item.voice_out);
                    errors++;
                end
            end
        end
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no beat moved for %0d cycles", $time, idle_cycles);
            $display("tb failed");
            $finish;
        end
    end

    vector_t vectors [] = '{
        // reset setting: 1024, bell
        '{16'd1024,  SHAPE_BELL,   4'd0,  16'd0,     1'b1, 16'd0},
        '{16'd1024,  SHAPE_BELL,   4'd15, 16'd512,   1'b0, 16'd0},
        '{16'd1024,  SHAPE_BELL,   4'd3,  16'd1023,  1'b0, 16'd0},
        '{16'd1024,  SHAPE_BELL,   4'd7,  16'd301,   1'b0, 16'd0},
        '{16'd1024,  SHAPE_BELL,   4'd5,  16'd1024,  1'b1, 16'd0},
        '{16'd1024,  SHAPE_BELL,   4'd10, 16'd65535, 1'b1, 16'd0},
        // largest grain, upper neighbor wraps at the last entry
        '{16'd65535, SHAPE_PERC,   4'd1,  16'd0,     1'b1, 16'd0},
        '{16'd65535, SHAPE_PERC,   4'd2,  16'd65534, 1'b0, 16'd0},
        '{16'd65535, SHAPE_PERC,   4'd4,  16'd8191,  1'b0, 16'd0},
        '{16'd65535, SHAPE_PERC,   4'd8,  16'd65535, 1'b1, 16'd0},
        '{16'd1,     SHAPE_SWELL,  4'd9,  16'd0,     1'b1, 16'd0},
        '{16'd1,     SHAPE_SWELL,  4'd6,  16'd1,     1'b1, 16'd0},
        '{16'd1,     SHAPE_SWELL,  4'd11, 16'd65535, 1'b1, 16'd0},
        // zero grain size: everything is past the grain
        '{16'd0,     SHAPE_BELL,   4'd12, 16'd0,     1'b1, 16'd0},
        '{16'd0,     SHAPE_BELL,   4'd13, 16'd65535, 1'b1, 16'd0},
        '{16'd700,   SHAPE_SILENT, 4'd14, 16'd350,   1'b1, 16'd0},
        '{16'd700,   SHAPE_SILENT, 4'd15, 16'd0,     1'b1, 16'd0},
        '{16'd700,   SHAPE_SWELL,  4'd0,  16'd612,   1'b0, 16'd0},
        '{16'd700,   SHAPE_SWELL,  4'd1,  16'd699,   1'b0, 16'd0},
        '{16'd3,     SHAPE_BELL,   4'd2,  16'd1,     1'b0, 16'd0},
        '{16'd3,     SHAPE_BELL,   4'd3,  16'd2,     1'b0, 16'd0},
        '{16'd512,   SHAPE_PERC,   4'd4,  16'd64,    1'b0, 16'd0},
        '{16'd512,   SHAPE_PERC,   4'd5,  16'd511,   1'b0, 16'd0}
    };

    initial
    begin : stimulus
        longint unsigned len;
        logic [GSIZE_W-1:0] size;
        logic [POS_W-1:0] pos;
        int n_beats, r, directed_beats;
        len = 64'(TABLE_LEN);
        for (longint unsigned n = 0; n < len; n++)
        begin
            bell_tab[n] = (2 * n <= len) ? raised_cos(2 * n, len)
                                         : raised_cos(2 * (len - n), len);
            perc_tab[n] = (8 * n <= len) ? raised_cos(8 * n, len)
                                         : raised_cos(8 * (len - n), 7 * len);
            swell_tab[n] = (8 * n <= 7 * len) ? raised_cos(8 * n, 7 * len)
                                              : raised_cos(8 * (len - n), len);
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (vectors[i])
        begin
            if (vectors[i].size != cur_size || vectors[i].shape != cur_shape)
                apply_setting(vectors[i].size, vectors[i].shape);
            send_beat(vectors[i].voice, vectors[i].pos, vectors[i].typed,
                      vectors[i].level);
        end
        directed_beats = beats_sent;

        while (beats_sent - directed_beats < RANDOM_BEATS)
        begin
            r = $urandom_range(0, 9);
            case (r)
                0: size = 16'd1;
                1: size = 16'd65535;
                2: size = 16'd0;
                3: size = 16'd512;
                4: size = 16'd1024;
                5, 6: size = GSIZE_W'($urandom_range(2, 64));
                default: size = GSIZE_W'($urandom_range(1, 65535));
            endcase
            calm = 1'b0;
            apply_setting(size, shape_t'($urandom_range(0, 3)));
            calm = ($urandom_range(0, 4) == 0);
            n_beats = $urandom_range(100, 160);
            repeat (n_beats)
            begin
                r = $urandom_range(0, 99);
                if (cur_size == 0 || r >= 90)
                    pos = POS_W'($urandom);
                else if (r >= 80)
                    pos = POS_W'($urandom_range(cur_size, 65535));
                else if (r >= 75)
                    pos = POS_W'(cur_size - 1'b1);
                else
                    pos = POS_W'($urandom_range(0, cur_size - 1));
                send_beat(4'($urandom), pos, 1'b0, '0);
            end
        end

        in_valid <= 1'b0;
        calm = 1'b0;
        @(posedge clk);
        while (pending_levels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("%0d beats (%0d directed), %0d results checked, %0d register settings",
                 beats_sent, directed_beats, results_checked, settings_applied);
        $display("beats per shape: bell %0d, perc %0d, swell %0d, silent %0d",
                 shape_beats[SHAPE_BELL], shape_beats[SHAPE_PERC],
                 shape_beats[SHAPE_SWELL], shape_beats[SHAPE_SILENT]);
        if (errors == 0 && pending_levels.size() == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/gelut_pkg.sv
hw/rtl/gelut_ram.sv
hw/rtl/gelut_front.sv
hw/rtl/gelut_queue.sv
hw/rtl/gelut_back.sv
hw/rtl/grain_envelope_lut_interp_unit.sv
tb/sv/tb.sv
